[hw/rtl/gppjt_pkg.sv]
// Shared types, constants and the target angle table for the gait phase PD torque core.
`default_nettype none
package gppjt_pkg;

  localparam int JOINT_COUNT  = 6;
  localparam int TARGET_SCALE = 65536;
  localparam int TABLE_JOINTS = 6;
  localparam int PHASE_COUNT  = 4;

  localparam int GAIN_W   = 24;
  localparam int PERIOD_W = 21;
  localparam int STEP_W   = 16;
  localparam int JOINT_W  = 3;
  localparam int ANGLE_W  = 24;
  localparam int RATE_W   = 24;
  localparam int PHASE_W  = 2;
  localparam int TORQUE_W = 34;

  // Scaled target fits a signed 25-bit word for any scale up to 2^23 - 1.
  localparam int TARGET_W = 25;
  localparam int DIFF_W   = TARGET_W + 1;
  localparam int PTERM_W  = GAIN_W + 1 + DIFF_W;
  localparam int DTERM_W  = GAIN_W + 1 + RATE_W;
  localparam int RAW_W    = PTERM_W + 1;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD = PERIOD_W'(65536);

  // Stream payload layout.
  localparam int IN_BITS     = STEP_W + JOINT_W + ANGLE_W + RATE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = TORQUE_W + PHASE_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = GAIN_W;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P       = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D       = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_PERIOD = CFG_INDEX_W'(2);

  localparam logic [GAIN_W-1:0]   GAIN_P_RESET       = GAIN_W'(76800);
  localparam logic [GAIN_W-1:0]   GAIN_D_RESET       = GAIN_W'(7680);
  localparam logic [PERIOD_W-1:0] PHASE_PERIOD_RESET = PERIOD_W'(1500000);

  // Round tenths * scale / 10, halves away from zero. Elaboration only.
  function automatic logic signed [TARGET_W-1:0] scale_tenths(input int tenths);
    int mag;
    int r;
    mag = (tenths < 0 ? -tenths : tenths) * TARGET_SCALE;
    r   = (mag + 5) / 10;
    return TARGET_W'(tenths < 0 ? -r : r);
  endfunction

  localparam logic signed [TARGET_W-1:0] TARGET_Q [PHASE_COUNT][TABLE_JOINTS] = '{
    '{scale_tenths(-10), scale_tenths(5),   scale_tenths(10),
      scale_tenths(-1),  scale_tenths(0),   scale_tenths(-1)},
    '{scale_tenths(-2),  scale_tenths(0),   scale_tenths(2),
      scale_tenths(0),   scale_tenths(1),   scale_tenths(0)},
    '{scale_tenths(5),   scale_tenths(-10), scale_tenths(-1),
      scale_tenths(10),  scale_tenths(-1),  scale_tenths(0)},
    '{scale_tenths(0),   scale_tenths(-2),  scale_tenths(0),
      scale_tenths(2),   scale_tenths(0),   scale_tenths(1)}
  };

  // Target angle for a phase and joint; joints beyond the table aim at zero.
  function automatic logic signed [TARGET_W-1:0] target_lookup(
    input logic [PHASE_W-1:0] phase,
    input logic [JOINT_W-1:0] joint
  );
    logic signed [TARGET_W-1:0] t;
    t = '0;
    if (int'(joint) < TABLE_JOINTS && int'(joint) < JOINT_COUNT) begin
      t = TARGET_Q[phase][joint];
    end
    return t;
  endfunction

  typedef struct packed {
    logic [PHASE_W-1:0]        phase;
    logic [JOINT_W-1:0]        joint;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [RATE_W-1:0]  rate;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0]        phase;
    logic signed [PTERM_W-1:0] p_term;
    logic signed [DTERM_W-1:0] d_term;
  } prod_t;

endpackage
`default_nettype wire

[hw/rtl/gppjt_phase_timer.sv]
// Microsecond gait timer and phase counter.
`default_nettype none
module gppjt_phase_timer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step_en,
  input  logic [gppjt_pkg::STEP_W-1:0]    time_step,
  input  logic [gppjt_pkg::PERIOD_W-1:0]  phase_period,
  output logic [gppjt_pkg::PHASE_W-1:0]   phase_now,
  output logic [gppjt_pkg::PHASE_W-1:0]   phase_number
);
  import gppjt_pkg::*;

  logic [PERIOD_W-1:0] time_in_phase;
  logic [PERIOD_W-1:0] time_in_phase_next;
  logic [PHASE_W-1:0]  phase_number_next;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   sum;
  logic [PERIOD_W:0]   rem;

  always_comb begin
    period = (phase_period < MIN_PERIOD) ? MIN_PERIOD : phase_period;
    sum    = {1'b0, time_in_phase} + {{(PERIOD_W + 1 - STEP_W){1'b0}}, time_step};
    rem    = sum - {1'b0, period};
    phase_number_next  = phase_number;
    time_in_phase_next = sum[PERIOD_W-1:0];
    if (sum >= {1'b0, period}) begin
      phase_number_next = phase_number + PHASE_W'(1);
      // timer still past a lowered period: restart the phase
      time_in_phase_next = (rem >= {1'b0, period}) ? '0 : rem[PERIOD_W-1:0];
    end
    phase_now = step_en ? phase_number_next : phase_number;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_number  <= '0;
      time_in_phase <= '0;
    end else if (step_en) begin
      phase_number  <= phase_number_next;
      time_in_phase <= time_in_phase_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gppjt_product_stage.sv]
// Target lookup and the two gain products, registered.
`default_nettype none
module gppjt_product_stage (
  input  logic                          clk,
  input  logic                          load,
  input  gppjt_pkg::item_t              item,
  input  logic [gppjt_pkg::GAIN_W-1:0]  gain_p,
  input  logic [gppjt_pkg::GAIN_W-1:0]  gain_d,
  output gppjt_pkg::prod_t              prod
);
  import gppjt_pkg::*;

  logic signed [TARGET_W-1:0] target;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [GAIN_W:0]     gp_s;
  logic signed [GAIN_W:0]     gd_s;
  prod_t                      prod_next;

  always_comb begin
    target = target_lookup(item.phase, item.joint);
    diff   = DIFF_W'(target) - DIFF_W'(item.angle);
    gp_s   = $signed({1'b0, gain_p});
    gd_s   = $signed({1'b0, gain_d});
    prod_next.phase  = item.phase;
    prod_next.p_term = gp_s * diff;
    prod_next.d_term = gd_s * item.rate;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gppjt_clamp_stage.sv]
// Torque difference, limit clamp and the result register.
`default_nettype none
module gppjt_clamp_stage (
  input  logic                                  clk,
  input  logic                                  load,
  input  gppjt_pkg::prod_t                      prod,
  input  logic [gppjt_pkg::GAIN_W-1:0]          gain_p,
  output logic signed [gppjt_pkg::TORQUE_W-1:0] drive_torque,
  output logic [gppjt_pkg::PHASE_W-1:0]         gait_phase,
  output logic                                  was_clamped
);
  import gppjt_pkg::*;

  logic signed [RAW_W-1:0]    raw;
  logic signed [RAW_W-1:0]    lim;
  logic signed [TORQUE_W-1:0] torque_lim;
  logic signed [TORQUE_W-1:0] torque_next;
  logic                       clamped_next;

  always_comb begin
    raw        = RAW_W'(prod.p_term) - RAW_W'(prod.d_term);
    lim        = $signed({{(RAW_W - GAIN_W - 16){1'b0}}, gain_p, 16'b0});
    torque_lim = $signed({{(TORQUE_W - GAIN_W - 8){1'b0}}, gain_p, 8'b0});
    clamped_next = 1'b1;
    if (raw > lim) begin
      torque_next = torque_lim;
    end else if (raw < -lim) begin
      torque_next = -torque_lim;
    end else begin
      // floor divide by 256; within the limit it fits the result width
      torque_next  = raw[TORQUE_W+7:8];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_torque <= torque_next;
      gait_phase   <= prod.phase;
      was_clamped  <= clamped_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gait_phase_pd_joint_torque_core.sv]
// Top level of the gait phase PD joint torque core.
`default_nettype none
// One joint sample enters per beat and one torque beat leaves for it. The
// sustained rate is one item per cycle when the output side is not stalled,
// set by the three-stage pipeline (input register, product register after
// the two gain multipliers, result register after the clamp); each stage
// takes a new beat when it is empty or its successor moves (output ready chain).
// A sample with tuser set first adds its time step to the microsecond gait
// timer and, once the timer reaches the phase period (never less than 65536),
// advances the gait phase 0..3; that same sample already uses the new phase.
// The phase and joint pick a signed Q8.16 target angle from a fixed table
// (joints past the table aim at zero). Torque is (gain_p * (target - angle)
// minus gain_d * rate) / 256 clamped to +/- 256 * gain_p; output tuser flags a clamp.
// Gains and period are written through the config channel, which is always
// ready; write them only while no sample is in flight.
module gait_phase_pd_joint_torque_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // slave stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // time_step[15:0], joint_index[18:16], joint_angle[42:19],
  // joint_rate[66:43], zero fill[71:67]
  input  logic [gppjt_pkg::IN_TDATA_W-1:0]      s_tdata,
  // first_of_update[0]
  input  logic                                  s_tuser,
  // master stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // drive_torque[33:0], gait_phase[35:34], zero fill[39:36]
  output logic [gppjt_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // was_clamped[0]
  output logic                                  m_tuser,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gppjt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gppjt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gppjt_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]   gain_p;
  logic [GAIN_W-1:0]   gain_d;
  logic [PERIOD_W-1:0] phase_period;

  // pipeline control
  logic in_valid;
  logic p_valid;
  logic out_ready;
  logic p_ready;
  logic in_ready;
  logic accept;

  item_t                      in_item;
  item_t                      in_item_next;
  prod_t                      prod;
  logic [PHASE_W-1:0]         phase_now;
  logic [PHASE_W-1:0]         phase_number;
  logic signed [TORQUE_W-1:0] drive_torque;
  logic [PHASE_W-1:0]         gait_phase;
  logic                       was_clamped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= GAIN_P_RESET;
      gain_d       <= GAIN_D_RESET;
      phase_period <= PHASE_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P:       gain_p       <= cfg_data;
        REG_GAIN_D:       gain_d       <= cfg_data;
        REG_PHASE_PERIOD: phase_period <= cfg_data[PERIOD_W-1:0];
        default:          ; // drop writes to unmapped indexes
      endcase
    end
  end

  // Each stage takes a new beat when it is empty or its successor moves.
  assign out_ready = !m_tvalid || m_tready;
  assign p_ready   = !p_valid || out_ready;
  assign in_ready  = !in_valid || p_ready;
  assign s_tready  = in_ready;
  assign accept    = s_tvalid && s_tready;

  // The timer updates on the accepting edge; the sample carries the new phase.
  gppjt_phase_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .step_en      (accept && s_tuser),
    .time_step    (s_tdata[STEP_W-1:0]),
    .phase_period (phase_period),
    .phase_now    (phase_now),
    .phase_number (phase_number)
  );

  always_comb begin
    in_item_next.phase = phase_now;
    in_item_next.joint = s_tdata[STEP_W +: JOINT_W];
    in_item_next.angle = $signed(s_tdata[STEP_W + JOINT_W +: ANGLE_W]);
    in_item_next.rate  = $signed(s_tdata[STEP_W + JOINT_W + ANGLE_W +: RATE_W]);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= in_item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      p_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid <= s_tvalid;
      end
      if (p_ready) begin
        p_valid <= in_valid;
      end
      if (out_ready) begin
        m_tvalid <= p_valid;
      end
    end
  end

  gppjt_product_stage u_product (
    .clk    (clk),
    .load   (p_ready && in_valid),
    .item   (in_item),
    .gain_p (gain_p),
    .gain_d (gain_d),
    .prod   (prod)
  );

  gppjt_clamp_stage u_clamp (
    .clk          (clk),
    .load         (out_ready && p_valid),
    .prod         (prod),
    .gain_p       (gain_p),
    .drive_torque (drive_torque),
    .gait_phase   (gait_phase),
    .was_clamped  (was_clamped)
  );

  assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, gait_phase, drive_torque};
  assign m_tuser = was_clamped;

`ifndef SYNTHESIS
  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while result register empty");

  // A result beat only appears after the product stage held one.
  a_out_from_product: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(p_valid))
    else $error("result beat without a product beat");

  // Samples that are not the first of an update leave the phase alone.
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tuser |=> $stable(phase_number))
    else $error("phase moved on a non-update sample");

  // An update moves the phase by at most one step.
  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser |=>
      (phase_number == $past(phase_number)) ||
      (phase_number == $past(phase_number) + PHASE_W'(1)))
    else $error("phase jumped more than one step");

  // The sample entering the pipeline carries the phase the timer now holds.
  a_item_phase: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_item.phase == phase_number)
    else $error("captured phase differs from timer phase");
`endif

endmodule
`default_nettype wire
